@@ rtl/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define PTE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PTE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define PTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/pte_pkg.sv @@
`timescale 1ns / 1ps

package pte_pkg;

    localparam int POOL_NODES_DEF = 4096;
    localparam int ALPHABET_DEF   = 26;
    localparam int COUNT_BITS_DEF = 16;

    localparam int OP_W     = 2;
    localparam int LETTER_W = 5;
    localparam int ANS_W    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_PREFIX = 2'd3
    } t_op;

endpackage

@@ rtl/pte_if.sv @@
`timescale 1ns / 1ps

interface pte_req_if;
    logic                          valid;
    logic                          ready;
    logic [pte_pkg::OP_W-1:0]      req_type;
    logic [pte_pkg::LETTER_W-1:0]  letter;
    logic                          last_letter;

    modport source (output valid, output req_type, output letter, output last_letter,
                    input ready);
    modport sink (input valid, input req_type, input letter, input last_letter,
                  output ready);
endinterface

interface pte_res_if;
    logic                        valid;
    logic                        ready;
    logic [pte_pkg::ANS_W-1:0]   answer;
    logic                        status;

    modport source (output valid, output answer, output status, input ready);
    modport sink (input valid, input answer, input status, output ready);
endinterface

@@ rtl/pte_ram.sv @@
`timescale 1ns / 1ps

module pte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pte_sat_unit.sv @@
`timescale 1ns / 1ps

module pte_sat_unit #(
    parameter int W = 16
) (
    input  logic [W-1:0] i_value,
    input  logic         i_down,
    output logic [W-1:0] o_result,
    output logic         o_zero
);

    always_comb begin
        o_zero = (i_value == '0);
        if (i_down) begin
            o_result = o_zero ? '0 : i_value - W'(1);
        end else begin
            o_result = (&i_value) ? i_value : i_value + W'(1);
        end
    end

endmodule

@@ rtl/prefix_trie_engine.sv @@
`timescale 1ns / 1ps
// prefix trie engine: lower-case word trie with word and prefix counts
// i_req carries one letter per request (req_type, letter, last_letter); the
// letter marked last_letter closes the word and yields one result on o_res
// (answer, status). other letters yield nothing.
// after reset a clearing pass writes zero to every node of the pool (POOL_NODES,
// 4096 by default), one node per cycle; i_req.ready stays low then.
// each request then passes through states until ready returns: a stopped walk
// or a bad letter goes straight to done, a missing child or a count step ends
// after the lookup, a prefix, insert or remove step adds a prefix count step,
// and the last letter of a count, insert or remove adds a word count step
// (child row read, prefix count read-modify-write, word count read-modify-write,
// all through one registered-read memory port each and one shared saturating
// count unit). the result is loaded into the output register in the last cycle
// and shows on o_res the cycle after.
// a stalled o_res keeps its result; the next request is still accepted, and
// the engine holds only when a new result finds the output register occupied.
// status high means the node pool ran out during that word.

`include "assert_macros.svh"

module prefix_trie_engine #(
    parameter int POOL_NODES = pte_pkg::POOL_NODES_DEF,
    parameter int ALPHABET   = pte_pkg::ALPHABET_DEF,
    parameter int COUNT_BITS = pte_pkg::COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pte_req_if.sink   i_req,
    pte_res_if.source o_res
);

    localparam int IDX_W  = $clog2(POOL_NODES);
    localparam int FREE_W = $clog2(POOL_NODES + 1);
    localparam int ROW_W  = ALPHABET * IDX_W;
    localparam int ANS_W  = pte_pkg::ANS_W;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_LOOK,
        ST_PCNT,
        ST_WCNT,
        ST_DONE
    } t_state;

    t_state                        r_state, n_state;
    pte_pkg::t_op                  r_op, n_op;
    logic [pte_pkg::LETTER_W-1:0]  r_letter, n_letter;
    logic                          r_last, n_last;
    logic [IDX_W-1:0]              r_cursor, n_cursor;
    logic [FREE_W-1:0]             r_free, n_free;
    logic                          r_stopped, n_stopped;
    logic                          r_overflow, n_overflow;
    logic [ANS_W-1:0]              r_len, n_len;
    logic [ANS_W-1:0]              r_ans, n_ans;
    logic [IDX_W-1:0]              r_clr_addr, n_clr_addr;
    logic                          r_out_valid, n_out_valid;
    logic [ANS_W-1:0]              r_out_answer, n_out_answer;
    logic                          r_out_status, n_out_status;

    logic [ROW_W-1:0]      row_rd;
    logic [ROW_W-1:0]      row_new;
    logic [IDX_W-1:0]      child;
    logic [IDX_W-1:0]      child_next;
    logic                  free_ok;
    logic                  alloc;
    logic [COUNT_BITS-1:0] pc_rd;
    logic [COUNT_BITS-1:0] wc_rd;
    logic [COUNT_BITS-1:0] unit_in;
    logic [COUNT_BITS-1:0] unit_out;
    logic                  unit_zero;
    logic [ANS_W-1:0]      w_ans;
    logic                  out_free;
    logic                  letter_bad;
    logic                  clearing;

    logic                  row_we;
    logic [IDX_W-1:0]      row_waddr;
    logic [ROW_W-1:0]      row_wdata;
    logic                  pc_we;
    logic                  wc_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [IDX_W-1:0]      cnt_raddr;

    // child lookup and row update
    always_comb begin
        child   = '0;
        row_new = row_rd;
        for (int a = 0; a < ALPHABET; a++) begin
            if (a == int'(r_letter)) begin
                child                      = row_rd[a*IDX_W +: IDX_W];
                row_new[a*IDX_W +: IDX_W]  = r_free[IDX_W-1:0];
            end
        end
    end

    assign free_ok    = (r_free < FREE_W'(POOL_NODES));
    assign alloc      = (child == '0) && free_ok;
    assign child_next = alloc ? r_free[IDX_W-1:0] : child;
    assign letter_bad = (int'(i_req.letter) >= ALPHABET);
    assign out_free   = !r_out_valid || o_res.ready;
    assign clearing   = (r_state == ST_CLR);

    generate
        if (COUNT_BITS > ANS_W) begin : g_ans_sat
            assign w_ans = (|wc_rd[COUNT_BITS-1:ANS_W]) ? '1 : wc_rd[ANS_W-1:0];
        end else begin : g_ans_ext
            assign w_ans = ANS_W'(wc_rd);
        end
    endgenerate

    // memory ports
    assign row_we    = clearing || ((r_state == ST_LOOK) && (r_op == pte_pkg::OP_INSERT)
                                    && alloc);
    assign row_waddr = clearing ? r_clr_addr : r_cursor;
    assign row_wdata = clearing ? '0 : row_new;

    assign pc_we     = clearing || ((r_state == ST_PCNT) &&
                                    ((r_op == pte_pkg::OP_INSERT) ||
                                     (r_op == pte_pkg::OP_REMOVE)));
    assign wc_we     = clearing || ((r_state == ST_WCNT) &&
                                    ((r_op == pte_pkg::OP_INSERT) ||
                                     (r_op == pte_pkg::OP_REMOVE)));
    assign cnt_waddr = clearing ? r_clr_addr : r_cursor;
    assign cnt_wdata = clearing ? '0 : unit_out;
    assign cnt_raddr = (r_state == ST_LOOK) ? child_next : r_cursor;

    assign unit_in = (r_state == ST_WCNT) ? wc_rd : pc_rd;

    pte_ram #(
        .WIDTH (ROW_W),
        .DEPTH (POOL_NODES)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (r_cursor),
        .o_rdata (row_rd)
    );

    pte_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (POOL_NODES)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (pc_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (pc_rd)
    );

    pte_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (POOL_NODES)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (wc_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (wc_rd)
    );

    pte_sat_unit #(
        .W (COUNT_BITS)
    ) u_sat (
        .i_value  (unit_in),
        .i_down   (r_op == pte_pkg::OP_REMOVE),
        .o_result (unit_out),
        .o_zero   (unit_zero)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_letter     = r_letter;
        n_last       = r_last;
        n_cursor     = r_cursor;
        n_free       = r_free;
        n_stopped    = r_stopped;
        n_overflow   = r_overflow;
        n_len        = r_len;
        n_ans        = r_ans;
        n_clr_addr   = r_clr_addr;
        n_out_valid  = r_out_valid;
        n_out_answer = r_out_answer;
        n_out_status = r_out_status;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLR: begin
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(POOL_NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op     = pte_pkg::t_op'(i_req.req_type);
                    n_letter = i_req.letter;
                    n_last   = i_req.last_letter;
                    n_ans    = '0;
                    if (r_stopped) begin
                        n_state = ST_DONE;
                    end else if (letter_bad) begin
                        n_stopped = 1'b1;
                        n_state   = ST_DONE;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (r_op == pte_pkg::OP_INSERT) begin
                    if ((child == '0) && !free_ok) begin
                        n_overflow = 1'b1;
                        n_stopped  = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        if (alloc) begin
                            n_free = r_free + FREE_W'(1);
                        end
                        n_cursor = child_next;
                        n_state  = ST_PCNT;
                    end
                end else if (child == '0) begin
                    n_stopped = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    n_cursor = child;
                    if (r_op == pte_pkg::OP_COUNT) begin
                        n_state = r_last ? ST_WCNT : ST_DONE;
                    end else begin
                        n_state = ST_PCNT;
                    end
                end
            end
            ST_PCNT: begin
                if (r_op == pte_pkg::OP_PREFIX) begin
                    if (unit_zero) begin
                        n_stopped = 1'b1;
                    end else if (r_len != '1) begin
                        n_len = r_len + ANS_W'(1);
                    end
                    n_state = ST_DONE;
                end else begin
                    n_state = r_last ? ST_WCNT : ST_DONE;
                end
            end
            ST_WCNT: begin
                if (r_op == pte_pkg::OP_COUNT) begin
                    n_ans = w_ans;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_overflow;
                    case (r_op)
                        pte_pkg::OP_COUNT:  n_out_answer = r_ans;
                        pte_pkg::OP_PREFIX: n_out_answer = r_len;
                        default:            n_out_answer = '0;
                    endcase
                    n_cursor   = '0;
                    n_stopped  = 1'b0;
                    n_len      = '0;
                    n_overflow = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_cursor    <= '0;
            r_free      <= FREE_W'(1);
            r_stopped   <= 1'b0;
            r_overflow  <= 1'b0;
            r_len       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_letter     <= n_letter;
            r_last       <= n_last;
            r_cursor     <= n_cursor;
            r_free       <= n_free;
            r_stopped    <= n_stopped;
            r_overflow   <= n_overflow;
            r_len        <= n_len;
            r_ans        <= n_ans;
            r_clr_addr   <= n_clr_addr;
            r_out_valid  <= n_out_valid;
            r_out_answer <= n_out_answer;
            r_out_status <= n_out_status;
        end
    end

    assign i_req.ready  = (r_state == ST_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.answer = r_out_answer;
    assign o_res.status = r_out_status;

    `PTE_ASSERT_IMPLIES(a_free_bound, i_clk, i_rst_n, 1'b1,
        r_free <= FREE_W'(POOL_NODES))
    `PTE_ASSERT_IMPLIES(a_overflow_stops, i_clk, i_rst_n, r_overflow, r_stopped)
    `PTE_ASSERT_IMPLIES(a_cursor_allocated, i_clk, i_rst_n, 1'b1,
        FREE_W'(r_cursor) < r_free)
    `PTE_ASSERT_NEXT(a_walk_cleared, i_clk, i_rst_n,
        (r_state == ST_DONE) && r_last && out_free,
        (r_cursor == '0) && !r_stopped && !r_overflow && r_out_valid)

endmodule
